@@ hdl/assert_macros.svh @@
// assertion macros used by the sorter rtl
// every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every sampled edge out of reset
`define GFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent one edge implies consequent at the next edge
`define GFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gfs_pkg.sv @@
// types, constants and helper functions for the grouped float sorter
// no dependencies; used by gfs_cell and grouped_float_sorter
`timescale 1ns / 1ps

package gfs_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int NUM_GROUPS   = 41;
  localparam int KEY_W        = 6;
  localparam int RAW_KEY_W    = 8;
  localparam int VAL_W        = 32;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 32;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] mapped;
  } gfs_entry_t;

  typedef struct packed {
    logic ins;    // broadcast item enters the chain
    logic drain;  // chain moves one place toward cell 0
  } gfs_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } gfs_state_t;

  // order-preserving map of float bits onto unsigned compare
  function automatic logic [VAL_W-1:0] order_map(input logic [VAL_W-1:0] bits);
    logic [VAL_W-1:0] res;
    if (bits[VAL_W-1]) begin
      res = ~bits;
    end else begin
      res = bits | {1'b1, {(VAL_W-1){1'b0}}};
    end
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] order_unmap(input logic [VAL_W-1:0] mapped);
    logic [VAL_W-1:0] res;
    if (mapped[VAL_W-1]) begin
      res = mapped ^ {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res = ~mapped;
    end
    return res;
  endfunction

  // negative keys go to group 0, large ones to the top group
  function automatic logic [KEY_W-1:0] clamp_key(input logic [RAW_KEY_W-1:0] raw);
    logic [KEY_W-1:0] res;
    if (raw[RAW_KEY_W-1]) begin
      res = '0;
    end else if (raw[RAW_KEY_W-2:0] > (RAW_KEY_W-1)'(NUM_GROUPS - 1)) begin
      res = KEY_W'(NUM_GROUPS - 1);
    end else begin
      res = raw[KEY_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ hdl/grouped_float_sorter.sv @@
// grouped float sorter top level: control, insertion chain of gfs_cell
// depends on gfs_pkg, gfs_cell and assert_macros.svh
//
// usage:
//   input beats carry a signed group key and float bits; in_tlast closes a set.
//   up to CAPACITY beats are kept per set, later ones are dropped and flagged.
//   loading takes one beat per cycle: each beat is compared against every
//   cell at once and slots into the sorted chain in the cycle it is accepted.
//   the cycle after the closing beat, results start on the out channel,
//   ordered by clamped key and then by float value (-0 before +0), one per
//   cycle while the receiver is ready; out_tlast marks the final one
//   and out_tuser is high on every result of a set that lost items.
//   while results drain, in_tready is low; the next set loads after the
//   final result is taken.
//   a stalled receiver simply holds the chain: cell 0 stays on out_tdata.
//   reset empties the chain and returns to loading.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grouped_float_sorter #(
  parameter int CAPACITY = gfs_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] group_key (signed), [39:8] value_bits
  input  logic [gfs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] sorted_value
  output logic [gfs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  // [0] items_dropped
  output logic                           out_tuser
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  gfs_pkg::gfs_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  gfs_pkg::gfs_ctrl_t  ctrl;

  gfs_pkg::gfs_entry_t new_ent;
  gfs_pkg::gfs_entry_t cell_ent [CAPACITY];
  logic                cell_lt  [CAPACITY];

  logic in_beat, out_beat;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  // broadcast item: clamped key and order-mapped value
  always_comb begin
    new_ent.valid  = 1'b1;
    new_ent.key    = gfs_pkg::clamp_key(in_tdata[gfs_pkg::RAW_KEY_W-1:0]);
    new_ent.mapped = gfs_pkg::order_map(
                       in_tdata[gfs_pkg::RAW_KEY_W +: gfs_pkg::VAL_W]);
  end

  // sorted chain, cell 0 holds the smallest entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    gfs_pkg::gfs_entry_t prev_ent, next_ent;
    logic                prev_lt;

    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_lt  = 1'b0;
    end else begin : g_body
      assign prev_ent = cell_ent[i-1];
      assign prev_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_mid
      assign next_ent = cell_ent[i+1];
    end

    gfs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .new_ent  (new_ent),
      .prev_ent (prev_ent),
      .prev_lt  (prev_lt),
      .next_ent (next_ent),
      .ent      (cell_ent[i]),
      .lt       (cell_lt[i])
    );
  end

  // load / drain sequencer
  // handshakes are decoded from the raw inputs so no output driven here feeds back
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    ctrl       = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      gfs_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (count_r < CNT_W'(CAPACITY)) begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;  // set too large, beat dropped
          end
          if (in_tlast) begin
            state_nxt = gfs_pkg::ST_DRAIN;
          end
        end
      end
      gfs_pkg::ST_DRAIN: begin
        out_tvalid = cell_ent[0].valid;
        if (cell_ent[0].valid && out_tready) begin
          ctrl.drain = 1'b1;
          if (out_tlast) begin
            state_nxt = gfs_pkg::ST_LOAD;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = gfs_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfs_pkg::ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // results come straight off cell 0
  assign out_tdata = gfs_pkg::order_unmap(cell_ent[0].mapped);
  assign out_tlast = !cell_ent[1].valid;
  assign out_tuser = ovf_r;

  `GFS_ASSERT(a_no_overlap, !(in_tready && out_tvalid), "load and drain overlap")
  `GFS_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "held count beyond capacity")
  `GFS_ASSERT_NEXT(a_close_starts_drain, in_beat && in_tlast,
                   out_tvalid && (state_r == gfs_pkg::ST_DRAIN),
                   "closing beat did not start the burst")
  `GFS_ASSERT_NEXT(a_burst_end_clears, out_beat && out_tlast,
                   !cell_ent[0].valid && (count_r == '0) && !ovf_r,
                   "chain not empty after final result")
  `GFS_ASSERT(a_chain_packed, !cell_ent[1].valid || cell_ent[0].valid,
              "chain head empty with entries behind it")

endmodule

@@ hdl/gfs_cell.sv @@
// one cell of the insertion chain: holds one entry, compares it to the
// broadcast item, takes from its left neighbor on insert and its right on drain
`timescale 1ns / 1ps

module gfs_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  gfs_pkg::gfs_ctrl_t  ctrl,
  input  gfs_pkg::gfs_entry_t new_ent,
  input  gfs_pkg::gfs_entry_t prev_ent,
  input  logic                prev_lt,
  input  gfs_pkg::gfs_entry_t next_ent,
  output gfs_pkg::gfs_entry_t ent,
  output logic                lt
);

  gfs_pkg::gfs_entry_t ent_r, ent_nxt;

  // empty cells act as +infinity so the flag is 0..0 1..1 along the chain
  assign lt = !ent_r.valid ||
              ({new_ent.key, new_ent.mapped} < {ent_r.key, ent_r.mapped});

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.drain) begin
      ent_nxt = next_ent;
    end else if (ctrl.ins && lt) begin
      ent_nxt = prev_lt ? prev_ent : new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule
